FILE: design/cwas_pkg.sv
package cwas_pkg;

   // cigar operation codes
   localparam logic [2:0] OP_MATCH    = 3'd0;
   localparam logic [2:0] OP_MISMATCH = 3'd1;
   localparam logic [2:0] OP_INS      = 3'd2;
   localparam logic [2:0] OP_DEL      = 3'd3;

   // field widths
   localparam int OP_W     = 3;
   localparam int LEN_W    = 32;
   localparam int THRESH_W = 16;
   localparam int OUT_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int ACC_W    = FRAC_W + 1;

   // threshold after reset
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd30;

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // one classified item as it waits in the queue
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [LEN_W-1:0] len;
      logic             first;
      logic             last;
      logic             long_hit;
   } entry_type;

endpackage

FILE: design/cigar_window_accuracy_scorer.sv
// CIGAR window accuracy scorer.
// Input channel (req_*): one CIGAR run per item, with first/last markers and
// the window's start and end offsets. An item is taken when req_valid is high
// and req_stall is low. A four-entry queue sits behind the input, so the
// sender sees req_stall only when that queue is full.
// Result channel (rsp_*): one item per window, after its last run: accuracy
// (UQ1.16, truncated), long-indel flag, empty flag, match and total counts.
// Configuration: csr_wr_en/csr_wr_data write the long-indel threshold; write
// it only while no window is in flight.
// Throughput: runs that are not last drain from the queue at one per cycle
// while the back end is idle. A last run holds the back end for the pop, the
// pairwise and total sums, a restoring divider giving one quotient bit a
// cycle, and the load of the output register.
// A result sits in the output register while rsp_stall is high; a next result
// then waits in the emit state, and the queue keeps taking runs until it fills.
// Reset (synchronous) clears counters, flags and queue and sets the
// threshold to 30.
module cigar_window_accuracy_scorer #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cwas_pkg::OP_W-1:0]        req_cigar_op,
   input  logic [cwas_pkg::LEN_W-1:0]       req_run_len,
   input  logic                             req_is_first,
   input  logic                             req_is_last,
   input  logic [cwas_pkg::LEN_W-1:0]       req_start_offset,
   input  logic [cwas_pkg::LEN_W-1:0]       req_end_offset,
   input  logic                             csr_wr_en,
   input  logic [cwas_pkg::THRESH_W-1:0]    csr_wr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cwas_pkg::ACC_W-1:0]       rsp_accuracy,
   output logic                             rsp_long_indel,
   output logic                             rsp_empty_window,
   output logic [cwas_pkg::OUT_W-1:0]       rsp_match_count,
   output logic [cwas_pkg::OUT_W-1:0]       rsp_total_count
);
   import cwas_pkg::*;

   logic      q_valid;
   logic      q_pop;
   entry_type q_entry;

   // classify and queue
   cwas_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cigar_op     (req_cigar_op),
      .req_run_len      (req_run_len),
      .req_is_first     (req_is_first),
      .req_is_last      (req_is_last),
      .req_start_offset (req_start_offset),
      .req_end_offset   (req_end_offset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop)
   );

   // count, divide and emit
   cwas_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accuracy     (rsp_accuracy),
      .rsp_long_indel   (rsp_long_indel),
      .rsp_empty_window (rsp_empty_window),
      .rsp_match_count  (rsp_match_count),
      .rsp_total_count  (rsp_total_count)
   );

endmodule

FILE: design/cwas_front.sv
module cwas_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cwas_pkg::OP_W-1:0]        req_cigar_op,
   input  logic [cwas_pkg::LEN_W-1:0]       req_run_len,
   input  logic                             req_is_first,
   input  logic                             req_is_last,
   input  logic [cwas_pkg::LEN_W-1:0]       req_start_offset,
   input  logic [cwas_pkg::LEN_W-1:0]       req_end_offset,
   input  logic                             csr_wr_en,
   input  logic [cwas_pkg::THRESH_W-1:0]    csr_wr_data,
   output logic                             q_valid,
   output cwas_pkg::entry_type              q_entry,
   input  logic                             q_pop
);
   import cwas_pkg::*;

   logic [THRESH_W-1:0]   thresh_ff;
   entry_type             fifo_mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  push;
   logic                  pop;
   logic [LEN_W-1:0]      trim_len;
   logic                  long_hit;
   entry_type             new_entry;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // trimmed length of this run
   always_comb begin
      priority if (req_is_first && req_is_last) begin
         trim_len = (req_end_offset > req_start_offset) ?
                    req_end_offset - req_start_offset : '0;
      end else if (req_is_first) begin
         trim_len = (req_run_len > req_start_offset) ?
                    req_run_len - req_start_offset : '0;
      end else if (req_is_last) begin
         trim_len = req_end_offset;
      end else begin
         trim_len = req_run_len;
      end
   end

   // long indel check on the untrimmed run
   assign long_hit = ((req_cigar_op == OP_INS) || (req_cigar_op == OP_DEL)) &&
                     (req_run_len >= LEN_W'(thresh_ff));

   always_comb begin
      new_entry.op       = req_cigar_op;
      new_entry.len      = trim_len;
      new_entry.first    = req_is_first;
      new_entry.last     = req_is_last;
      new_entry.long_hit = long_hit;
   end

   // queue control
   assign req_stall = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = fifo_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue fill count above depth");

   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == FIFO_CNT_W'($past(cnt_ff) + 1'b1)))
      else $error("queue count did not grow on push");

   a_pop_shrink: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (cnt_ff == FIFO_CNT_W'($past(cnt_ff) - 1'b1)))
      else $error("queue count did not shrink on pop");
`endif

endmodule

FILE: design/cwas_back.sv
module cwas_back #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  cwas_pkg::entry_type              q_entry,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cwas_pkg::ACC_W-1:0]       rsp_accuracy,
   output logic                             rsp_long_indel,
   output logic                             rsp_empty_window,
   output logic [cwas_pkg::OUT_W-1:0]       rsp_match_count,
   output logic [cwas_pkg::OUT_W-1:0]       rsp_total_count
);
   import cwas_pkg::*;

   localparam int XW    = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
   localparam int SW    = ((COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W) + 1;
   localparam int DCNTW = $clog2(ACC_W);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SUM   = 5'b00010,
      ST_TOTAL = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] match_ff, match_in;
   logic [COUNT_WIDTH-1:0] mism_ff, mism_in;
   logic [COUNT_WIDTH-1:0] ins_ff, ins_in;
   logic [COUNT_WIDTH-1:0] del_ff, del_in;
   logic                   stopped_ff, stopped_in;
   logic                   indel_ff, indel_in;
   logic [COUNT_WIDTH-1:0] pair_a_ff, pair_a_in;
   logic [COUNT_WIDTH-1:0] pair_b_ff, pair_b_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [COUNT_WIDTH:0]   rem_ff, rem_in;
   logic [ACC_W-1:0]       quo_ff, quo_in;
   logic [DCNTW-1:0]       dcnt_ff, dcnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]       acc_ff;
   logic                   long_ff;
   logic                   empty_ff;
   logic [OUT_W-1:0]       mcnt_ff;
   logic [OUT_W-1:0]       tcnt_ff;

   logic [COUNT_WIDTH-1:0] base_match, base_mism, base_ins, base_del;
   logic                   base_stopped, base_indel;
   logic [COUNT_WIDTH-1:0] sel_cnt;
   logic [SW-1:0]          run_sum;
   logic [COUNT_WIDTH-1:0] run_sat;
   logic [COUNT_WIDTH:0]   sum_a, sum_b, sum_t;
   logic                   rem_ge;
   logic                   out_free;
   logic                   load_out;
   logic                   empty_now;
   logic [XW-1:0]          match_ext, total_ext;
   logic [OUT_W-1:0]       match_clip, total_clip;

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == ST_EMIT) && out_free;

   // window restart on the first run
   always_comb begin
      if (q_entry.first) begin
         base_match   = '0;
         base_mism    = '0;
         base_ins     = '0;
         base_del     = '0;
         base_stopped = 1'b0;
         base_indel   = 1'b0;
      end else begin
         base_match   = match_ff;
         base_mism    = mism_ff;
         base_ins     = ins_ff;
         base_del     = del_ff;
         base_stopped = stopped_ff;
         base_indel   = indel_ff;
      end
   end

   // one saturating add into the counter of this run's kind
   always_comb begin
      unique case (q_entry.op)
         OP_MATCH:    sel_cnt = base_match;
         OP_MISMATCH: sel_cnt = base_mism;
         OP_INS:      sel_cnt = base_ins;
         OP_DEL:      sel_cnt = base_del;
         default:     sel_cnt = '0;
      endcase
      run_sum = SW'(sel_cnt) + SW'(q_entry.len);
      run_sat = ((run_sum >> COUNT_WIDTH) != '0) ? '1 : run_sum[COUNT_WIDTH-1:0];
   end

   // pairwise and final saturating sums for the total
   always_comb begin
      sum_a = {1'b0, match_ff} + {1'b0, mism_ff};
      sum_b = {1'b0, ins_ff} + {1'b0, del_ff};
      sum_t = {1'b0, pair_a_ff} + {1'b0, pair_b_ff};
   end

   // restoring division step: one quotient bit a cycle
   assign rem_ge    = (rem_ff >= {1'b0, total_ff});
   assign empty_now = (total_ff == '0);

   // output clipping to 32 bits
   always_comb begin
      match_ext  = XW'(match_ff);
      total_ext  = XW'(total_ff);
      match_clip = ((match_ext >> OUT_W) != '0) ? '1 : match_ext[OUT_W-1:0];
      total_clip = ((total_ext >> OUT_W) != '0) ? '1 : total_ext[OUT_W-1:0];
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      match_in     = match_ff;
      mism_in      = mism_ff;
      ins_in       = ins_ff;
      del_in       = del_ff;
      stopped_in   = stopped_ff;
      indel_in     = indel_ff;
      pair_a_in    = pair_a_ff;
      pair_b_in    = pair_b_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               match_in   = base_match;
               mism_in    = base_mism;
               ins_in     = base_ins;
               del_in     = base_del;
               indel_in   = base_indel | q_entry.long_hit;
               stopped_in = base_stopped | (q_entry.len == '0);
               if (!stopped_in) begin
                  unique case (q_entry.op)
                     OP_MATCH:    match_in = run_sat;
                     OP_MISMATCH: mism_in  = run_sat;
                     OP_INS:      ins_in   = run_sat;
                     OP_DEL:      del_in   = run_sat;
                     default:     ;
                  endcase
               end
               if (q_entry.last) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            pair_a_in = sum_a[COUNT_WIDTH] ? '1 : sum_a[COUNT_WIDTH-1:0];
            pair_b_in = sum_b[COUNT_WIDTH] ? '1 : sum_b[COUNT_WIDTH-1:0];
            state_in  = ST_TOTAL;
         end
         ST_TOTAL: begin
            total_in = sum_t[COUNT_WIDTH] ? '1 : sum_t[COUNT_WIDTH-1:0];
            rem_in   = {1'b0, match_ff};
            quo_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ge) begin
               rem_in = (rem_ff - {1'b0, total_ff}) << 1;
            end else begin
               rem_in = rem_ff << 1;
            end
            quo_in  = {quo_ff[ACC_W-2:0], rem_ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNTW'(ACC_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         match_ff     <= '0;
         mism_ff      <= '0;
         ins_ff       <= '0;
         del_ff       <= '0;
         stopped_ff   <= 1'b0;
         indel_ff     <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         match_ff     <= match_in;
         mism_ff      <= mism_in;
         ins_ff       <= ins_in;
         del_ff       <= del_in;
         stopped_ff   <= stopped_in;
         indel_ff     <= indel_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // divider working registers
   always_ff @(posedge clock) begin
      pair_a_ff <= pair_a_in;
      pair_b_ff <= pair_b_in;
      total_ff  <= total_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         acc_ff   <= empty_now ? '0 : quo_ff;
         long_ff  <= indel_ff;
         empty_ff <= empty_now;
         mcnt_ff  <= match_clip;
         tcnt_ff  <= total_clip;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accuracy     = acc_ff;
   assign rsp_long_indel   = long_ff;
   assign rsp_empty_window = empty_ff;
   assign rsp_match_count  = mcnt_ff;
   assign rsp_total_count  = tcnt_ff;

`ifndef ASSERT_OFF
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (acc_ff <= ACC_W'(1 << FRAC_W)))
      else $error("accuracy above one");

   a_empty_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && empty_ff) |-> ((acc_ff == '0) && (mcnt_ff == '0)))
      else $error("empty window with nonzero accuracy or matches");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && (dcnt_ff == DCNTW'(ACC_W - 1))) |=> (state_ff == ST_EMIT))
      else $error("division did not finish after all quotient bits");
`endif

endmodule
